@@ src/slcfr_pkg.sv @@
package slcfr_pkg;

  localparam logic [7:0] SYNC_FIRST   = 8'hFF;
  localparam logic [7:0] SYNC_SECOND  = 8'h55;
  localparam logic [7:0] GROUP_UPDATE = 8'h40;
  localparam logic [7:0] STATUS_OK    = 8'h01;
  localparam logic [7:0] STAGE_MAX    = 8'h05;
  localparam logic [7:0] HEAD_COUNT   = 8'd3;

  localparam logic [1:0] VERDICT_NONE = 2'd0;
  localparam logic [1:0] VERDICT_OK   = 2'd1;
  localparam logic [1:0] VERDICT_FAIL = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_SYNC2 = 2'd1,
    PH_LEN   = 2'd2,
    PH_BODY  = 2'd3
  } phase_e;

  // one finished frame handed from the parser to the decoder
  typedef struct packed {
    logic       good;
    logic [7:0] length;
    logic [7:0] head0;
    logic [7:0] head1;
    logic [7:0] head2;
  } frame_rec_t;

endpackage

@@ src/slcfr_if.sv @@
interface slcfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcfr_out_if;
  logic       valid;
  logic       ready;
  logic       checksum_ok;
  logic [7:0] payload_length;
  logic [7:0] group_byte;
  logic [7:0] stage_code;
  logic [1:0] stage_verdict;
  logic [2:0] confirmed_stage;
  logic       frame_event;

  modport source (output valid, output checksum_ok, output payload_length,
                  output group_byte, output stage_code, output stage_verdict,
                  output confirmed_stage, output frame_event, input ready);
  modport sink   (input valid, input checksum_ok, input payload_length,
                  input group_byte, input stage_code, input stage_verdict,
                  input confirmed_stage, input frame_event, output ready);
endinterface

@@ src/slcfr_front.sv @@
module slcfr_front import slcfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       beat_i,
  input  logic [7:0] byte_i,
  output logic       push_o,
  output frame_rec_t rec_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] head_q [3];
  logic [7:0] head_d [3];
  logic [7:0] limit;
  logic       in_body;

  assign limit   = (len_q == 8'd0) ? 8'd0 : len_q - 8'd1;
  assign in_body = cnt_q < limit;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (beat_i) begin
      case (phase_q)
        PH_HUNT:  if (byte_i == SYNC_FIRST) phase_d = PH_SYNC2;
        PH_SYNC2: phase_d = (byte_i == SYNC_SECOND) ? PH_LEN : PH_HUNT;
        PH_LEN:   phase_d = PH_BODY;
        PH_BODY:  if (!in_body) phase_d = PH_HUNT;
        default:  phase_d = PH_HUNT;
      endcase
    end
  end

  // datapath and frame hand-off
  always_comb begin
    len_d  = len_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    head_d = head_q;
    push_o = 1'b0;
    rec_o  = '{good: (byte_i == sum_q), length: cnt_q,
               head0: head_q[0], head1: head_q[1], head2: head_q[2]};
    if (beat_i) begin
      case (phase_q)
        PH_LEN: begin
          len_d = byte_i;
          sum_d = byte_i;
          cnt_d = 8'd0;
        end
        PH_BODY: begin
          if (in_body) begin
            if (cnt_q < HEAD_COUNT) head_d[cnt_q[1:0]] = byte_i;
            sum_d = sum_q + byte_i;
            cnt_d = cnt_q + 8'd1;
          end else begin
            push_o = 1'b1;
            sum_d  = 8'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= 8'd0;
      cnt_q   <= 8'd0;
      sum_q   <= 8'd0;
      head_q  <= '{default: 8'd0};
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      head_q  <= head_d;
    end
  end

endmodule

@@ src/slcfr_fifo.sv @@
module slcfr_fifo import slcfr_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  frame_rec_t data_i,
  output logic       full_o,
  output logic       valid_o,
  input  logic       pop_i,
  output frame_rec_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  frame_rec_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ src/slcfr_back.sv @@
module slcfr_back import slcfr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rec_valid_i,
  input  frame_rec_t    rec_i,
  output logic          pop_o,
  slcfr_out_if.source   res_o
);

  logic       valid_q;
  logic [2:0] conf_q, conf_d;
  logic [1:0] verdict_d;
  logic       take;
  logic       known;

  assign take  = rec_valid_i && (!valid_q || res_o.ready);
  assign pop_o = take;
  assign known = rec_i.good && (rec_i.head0 == GROUP_UPDATE) && (rec_i.head1 <= STAGE_MAX);

  always_comb begin
    verdict_d = VERDICT_NONE;
    conf_d    = conf_q;
    if (known) begin
      if (rec_i.head2 == STATUS_OK) begin
        verdict_d = VERDICT_OK;
        conf_d    = rec_i.head1[2:0] + 3'd1;
      end else begin
        verdict_d = VERDICT_FAIL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      conf_q  <= 3'd0;
    end else begin
      if (take) begin
        valid_q <= 1'b1;
        conf_q  <= conf_d;
      end else if (res_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_o.checksum_ok     <= rec_i.good;
      res_o.payload_length  <= rec_i.length;
      res_o.group_byte      <= rec_i.good ? rec_i.head0 : 8'd0;
      res_o.stage_code      <= rec_i.good ? rec_i.head1 : 8'd0;
      res_o.stage_verdict   <= verdict_d;
      res_o.confirmed_stage <= conf_d;
      res_o.frame_event     <= rec_i.good;
    end
  end

  assign res_o.valid = valid_q;

endmodule

@@ src/sync_length_checksum_frame_receiver_core.sv @@
// Frame receiver for a byte stream: hunts for the sync pair ff 55, takes a
// length byte L, collects L-1 payload bytes (a length of zero means no
// payload), then checks the next byte against the 8-bit sum of the length
// and payload bytes. Each completed frame gives one result beat carrying the
// checksum verdict, the payload length and, on a good frame, the decoded
// group/stage/status reply plus the held last-confirmed stage. Payloads
// shorter than three bytes decode with whatever head bytes earlier frames
// left behind. Input takes one byte per cycle; the parser holds ready low
// only while the frame queue (FifoDepth entries) is full, which, with a
// FifoDepth above one, happens only when the result side stalls. A frame
// is stored in the queue when its checksum byte is accepted; the decoder's
// output register loads it when that register is free or being drained.
module sync_length_checksum_frame_receiver_core import slcfr_pkg::*; #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slcfr_in_if.sink    rx_i,
  slcfr_out_if.source res_o
);

  logic       beat;
  logic       push;
  logic       full;
  logic       rec_valid;
  logic       pop;
  frame_rec_t rec_in;
  frame_rec_t rec_out;

  // parser stalls only when the queue has no room for a finished frame
  assign rx_i.ready = !full;
  assign beat       = rx_i.valid && rx_i.ready;

  // front: sync hunt, length, checksum accumulation
  slcfr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .byte_i (rx_i.rx_byte),
    .push_o (push),
    .rec_o  (rec_in)
  );

  // short queue decoupling parser from result side
  slcfr_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (rec_in),
    .full_o  (full),
    .valid_o (rec_valid),
    .pop_i   (pop),
    .data_o  (rec_out)
  );

  // back: reply decode, held stage status, result register
  slcfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_i       (rec_out),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule
